// File: sv/lazy_range_add_sum_tree_macros.svh
// Assertion macros used by the segment tree datapath.
`ifndef LAZY_RANGE_ADD_SUM_TREE_MACROS_SVH
`define LAZY_RANGE_ADD_SUM_TREE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define LRAST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define LRAST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lrast_pkg.sv
// Types shared by the segment tree controller and datapath.
package lrast_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_ADD   = 2'd2,
    OP_SUM   = 2'd3
  } opcode_e;

  // Node memory read address source
  typedef enum logic [1:0] {
    AS_CUR   = 2'd0,
    AS_TAG   = 2'd1,
    AS_LEFT  = 2'd2,
    AS_RIGHT = 2'd3
  } addr_sel_e;

  // Which node a tag sequence is updating
  typedef enum logic [1:0] {
    TK_COVER = 2'd0,
    TK_LEFT  = 2'd1,
    TK_RIGHT = 2'd2
  } tag_kind_e;

  // Controller states
  typedef enum logic [14:0] {
    S_CLEAR    = 15'h0001,
    S_IDLE     = 15'h0002,
    S_START    = 15'h0004,
    S_VISIT    = 15'h0008,
    S_LEAF     = 15'h0010,
    S_COV_RD   = 15'h0020,
    S_PUSH_RD  = 15'h0040,
    S_TAG_RD   = 15'h0080,
    S_TAG_MUL  = 15'h0100,
    S_TAG_WR   = 15'h0200,
    S_RET      = 15'h0400,
    S_COMB_RD1 = 15'h0800,
    S_COMB_RD2 = 15'h1000,
    S_COMB_WR  = 15'h2000,
    S_EMIT     = 15'h4000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic      load_item;
    logic      write_base;
    logic      init_root;
    logic      acc_add;
    logic      rd_en;
    addr_sel_e rd_sel;
    logic      base_rd;
    logic      leaf_write;
    logic      pend_zero;
    logic      latch_t;
    logic      tag_cover;
    logic      tag_left;
    logic      tag_right;
    logic      mul;
    logic      tag_write;
    logic      stk_push;
    logic      stk_right;
    logic      stk_pop;
    logic      comb_latch;
    logic      comb_write;
    logic      clr_write;
    logic      out_load;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    opcode_e op;
    logic    range_empty;
    logic    disjoint;
    logic    covered;
    logic    leaf;
    logic    sp_empty;
    logic    top_phase;
    logic    clr_done;
    logic    out_free;
  } dp_status_t;

endpackage

// File: sv/lrast_ctrl.sv
// Sequencer that walks the segment tree for build, range add and range sum.
module lrast_ctrl
  import lrast_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e    state_q, state_d;
  tag_kind_e tk_q, tk_d;

  // State and tag-kind registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      tk_q    <= TK_COVER;
    end else begin
      state_q <= state_d;
      tk_q    <= tk_d;
    end
  end

  // Next state and commands
  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    tk_d       = tk_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        if (status_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_START;
        end
      end
      S_START: begin
        case (status_i.op)
          OP_LOAD: begin
            cmd_o.write_base = 1'b1;
            state_d = S_IDLE;
          end
          OP_BUILD: begin
            cmd_o.init_root = 1'b1;
            state_d = S_VISIT;
          end
          OP_ADD: begin
            if (status_i.range_empty) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.init_root = 1'b1;
              state_d = S_VISIT;
            end
          end
          default: begin
            if (status_i.range_empty) begin
              state_d = S_EMIT;
            end else begin
              cmd_o.init_root = 1'b1;
              state_d = S_VISIT;
            end
          end
        endcase
      end
      S_VISIT: begin
        if (status_i.op == OP_BUILD) begin
          cmd_o.pend_zero = 1'b1;
          if (status_i.leaf) begin
            cmd_o.base_rd = 1'b1;
            state_d = S_LEAF;
          end else begin
            cmd_o.stk_push = 1'b1;
          end
        end else if (status_i.disjoint) begin
          state_d = S_RET;
        end else if (status_i.covered) begin
          if (status_i.op == OP_SUM) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = AS_CUR;
            state_d = S_COV_RD;
          end else begin
            cmd_o.tag_cover = 1'b1;
            tk_d = TK_COVER;
            state_d = S_TAG_RD;
          end
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = AS_CUR;
          state_d = S_PUSH_RD;
        end
      end
      S_LEAF: begin
        cmd_o.leaf_write = 1'b1;
        state_d = S_RET;
      end
      S_COV_RD: begin
        cmd_o.acc_add = 1'b1;
        state_d = S_RET;
      end
      S_PUSH_RD: begin
        cmd_o.latch_t   = 1'b1;
        cmd_o.pend_zero = 1'b1;
        cmd_o.tag_left  = 1'b1;
        tk_d = TK_LEFT;
        state_d = S_TAG_RD;
      end
      S_TAG_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = AS_TAG;
        state_d = S_TAG_MUL;
      end
      S_TAG_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_TAG_WR;
      end
      S_TAG_WR: begin
        cmd_o.tag_write = 1'b1;
        case (tk_q)
          TK_LEFT: begin
            cmd_o.tag_right = 1'b1;
            tk_d = TK_RIGHT;
            state_d = S_TAG_RD;
          end
          TK_RIGHT: begin
            cmd_o.stk_push = 1'b1;
            state_d = S_VISIT;
          end
          default: state_d = S_RET;
        endcase
      end
      S_RET: begin
        if (status_i.sp_empty) begin
          state_d = (status_i.op == OP_SUM) ? S_EMIT : S_IDLE;
        end else if (!status_i.top_phase) begin
          cmd_o.stk_right = 1'b1;
          state_d = S_VISIT;
        end else begin
          cmd_o.stk_pop = 1'b1;
          if (status_i.op != OP_SUM) state_d = S_COMB_RD1;
        end
      end
      S_COMB_RD1: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = AS_LEFT;
        state_d = S_COMB_RD2;
      end
      S_COMB_RD2: begin
        cmd_o.comb_latch = 1'b1;
        cmd_o.rd_en      = 1'b1;
        cmd_o.rd_sel     = AS_RIGHT;
        state_d = S_COMB_WR;
      end
      S_COMB_WR: begin
        cmd_o.comb_write = 1'b1;
        state_d = S_RET;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

// File: sv/lrast_dp.sv
// Datapath: node memories, element store, walk stack, tag multiplier, output register.
module lrast_dp
  import lrast_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [55:0] s_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata
);

  `include "lazy_range_add_sum_tree_macros.svh"

  localparam int PW   = $clog2(MAX_ELEMENTS);
  localparam int CW   = (PW > 10) ? PW : 10;
  localparam int SW   = PW + 1;
  localparam int NS   = 4 * MAX_ELEMENTS;
  localparam int NW   = $clog2(NS);
  localparam int SD   = PW + 1;
  localparam int SPW  = $clog2(SD + 1);
  localparam int SIW  = $clog2(SD);

  // Item registers
  opcode_e      op_q;
  logic [9:0]   l_q, r_q;
  logic [63:0]  amt_q;
  logic [31:0]  val_q;
  logic [10:0]  cnt_q;

  // Walk state
  logic [NW-1:0] cur_node_q;
  logic [PW-1:0] cur_lo_q, cur_hi_q;
  logic [NW-1:0] stk_node [SD];
  logic [PW-1:0] stk_lo   [SD];
  logic [PW-1:0] stk_hi   [SD];
  logic          stk_ph   [SD];
  logic [SPW-1:0] sp_q;

  // Tag unit
  logic [NW-1:0]   tnode_q;
  logic [SW-1:0]   tsize_q;
  logic [63:0]     tamt_q, t_q;
  logic [32+SW-1:0] plo_q, phi_q;
  logic [63:0]     prod;

  // Memories and read data
  logic [63:0] sum_mem  [NS];
  logic [63:0] pend_mem [NS];
  logic [31:0] base_mem [MAX_ELEMENTS];
  logic [63:0] rd_sum_q, rd_pend_q, comb_q, acc_q, out_q;
  logic [31:0] base_q;
  logic        m_valid_q;
  logic [NW-1:0] clr_q;

  // Derived values
  logic [NW-1:0] cur_left, cur_right, top_left_n, top_right_n, rd_addr;
  logic [PW-1:0] cur_mid, top_mid;
  logic [SIW-1:0] top_idx, push_idx;
  logic [CW-1:0] lo_c, hi_c, l_c, r_c;
  logic [31:0]   n_w;
  logic          sum_we, pend_we;
  logic [NW-1:0] sum_wa, pend_wa;
  logic [63:0]   sum_wd, pend_wd;

  assign top_idx  = SIW'(sp_q - SPW'(1));
  assign push_idx = SIW'(sp_q);
  assign cur_mid  = cur_lo_q + ((cur_hi_q - cur_lo_q) >> 1);
  assign top_mid  = stk_lo[top_idx] + ((stk_hi[top_idx] - stk_lo[top_idx]) >> 1);
  assign cur_left    = {cur_node_q[NW-2:0], 1'b0};
  assign cur_right   = {cur_node_q[NW-2:0], 1'b1};
  assign top_left_n  = {stk_node[top_idx][NW-2:0], 1'b0};
  assign top_right_n = {stk_node[top_idx][NW-2:0], 1'b1};
  assign lo_c = CW'(cur_lo_q);
  assign hi_c = CW'(cur_hi_q);
  assign l_c  = CW'(l_q);
  assign r_c  = CW'(r_q);

  // Active element count, clamped to [1, MAX_ELEMENTS]
  always_comb begin
    if (cnt_q == '0) n_w = 32'd1;
    else if (32'(cnt_q) > 32'(MAX_ELEMENTS)) n_w = 32'(MAX_ELEMENTS);
    else n_w = 32'(cnt_q);
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 11'd1024;
    else if (cfg_we_i) cnt_q <= cfg_wdata_i;
  end

  // Input item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= opcode_e'(s_axis_tdata[1:0]);
      l_q   <= s_axis_tdata[11:2];
      r_q   <= s_axis_tdata[21:12];
      val_q <= s_axis_tdata[53:22];
      amt_q <= {{32{s_axis_tdata[53]}}, s_axis_tdata[53:22]};
    end
  end

  // Current node and walk stack
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else if (cmd_i.init_root) begin
      sp_q <= '0;
    end else if (cmd_i.stk_push) begin
      sp_q <= sp_q + SPW'(1);
    end else if (cmd_i.stk_pop) begin
      sp_q <= sp_q - SPW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_root) begin
      cur_node_q <= NW'(1);
      cur_lo_q   <= '0;
      cur_hi_q   <= PW'(n_w - 32'd1);
    end else if (cmd_i.stk_push) begin
      stk_node[push_idx] <= cur_node_q;
      stk_lo[push_idx]   <= cur_lo_q;
      stk_hi[push_idx]   <= cur_hi_q;
      stk_ph[push_idx]   <= 1'b0;
      cur_node_q <= cur_left;
      cur_hi_q   <= cur_mid;
    end else if (cmd_i.stk_right) begin
      stk_ph[top_idx] <= 1'b1;
      cur_node_q <= top_right_n;
      cur_lo_q   <= top_mid + PW'(1);
      cur_hi_q   <= stk_hi[top_idx];
    end else if (cmd_i.stk_pop) begin
      cur_node_q <= stk_node[top_idx];
      cur_lo_q   <= stk_lo[top_idx];
      cur_hi_q   <= stk_hi[top_idx];
    end
  end

  // Tag target setup and split multiply
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_t) t_q <= rd_pend_q;
    if (cmd_i.tag_cover) begin
      tnode_q <= cur_node_q;
      tsize_q <= {1'b0, cur_hi_q} - {1'b0, cur_lo_q} + SW'(1);
      tamt_q  <= amt_q;
    end else if (cmd_i.tag_left) begin
      tnode_q <= cur_left;
      tsize_q <= {1'b0, cur_mid} - {1'b0, cur_lo_q} + SW'(1);
      tamt_q  <= rd_pend_q;
    end else if (cmd_i.tag_right) begin
      tnode_q <= cur_right;
      tsize_q <= {1'b0, cur_hi_q} - {1'b0, cur_mid};
      tamt_q  <= t_q;
    end
    if (cmd_i.mul) begin
      plo_q <= tamt_q[31:0] * tsize_q;
      phi_q <= tamt_q[63:32] * tsize_q;
    end
  end

  assign prod = {phi_q[31:0], 32'd0} + 64'(plo_q);

  // Node memory port muxing
  always_comb begin
    case (cmd_i.rd_sel)
      AS_CUR:   rd_addr = cur_node_q;
      AS_TAG:   rd_addr = tnode_q;
      AS_LEFT:  rd_addr = cur_left;
      default:  rd_addr = cur_right;
    endcase
    sum_we = 1'b1;
    sum_wa = cur_node_q;
    sum_wd = '0;
    if (cmd_i.clr_write) begin
      sum_wa = clr_q;
    end else if (cmd_i.leaf_write) begin
      sum_wd = {{32{base_q[31]}}, base_q};
    end else if (cmd_i.tag_write) begin
      sum_wa = tnode_q;
      sum_wd = rd_sum_q + prod;
    end else if (cmd_i.comb_write) begin
      sum_wd = comb_q + rd_sum_q;
    end else begin
      sum_we = 1'b0;
    end
    pend_we = 1'b1;
    pend_wa = cur_node_q;
    pend_wd = '0;
    if (cmd_i.clr_write) begin
      pend_wa = clr_q;
    end else if (cmd_i.tag_write) begin
      pend_wa = tnode_q;
      pend_wd = rd_pend_q + tamt_q;
    end else if (!cmd_i.pend_zero) begin
      pend_we = 1'b0;
    end
  end

  // Node sum and pending tag memories
  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    if (cmd_i.rd_en) rd_sum_q <= sum_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    if (cmd_i.rd_en) rd_pend_q <= pend_mem[rd_addr];
  end

  // Element store
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_base && (32'(l_q) < 32'(MAX_ELEMENTS))) base_mem[PW'(l_q)] <= val_q;
    if (cmd_i.base_rd) base_q <= base_mem[cur_lo_q];
  end

  // Combine temp and sum accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.comb_latch) comb_q <= rd_sum_q;
    if (cmd_i.load_item) acc_q <= '0;
    else if (cmd_i.acc_add) acc_q <= acc_q + rd_sum_q;
  end

  // Clearing sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_write) clr_q <= clr_q + NW'(1);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else if (cmd_i.out_load) m_valid_q <= 1'b1;
    else if (m_axis_tready) m_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= acc_q;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

  // Status back to the controller
  always_comb begin
    status_o.op          = op_q;
    status_o.range_empty = (l_q > r_q);
    status_o.disjoint    = (lo_c > r_c) || (hi_c < l_c);
    status_o.covered     = (l_c <= lo_c) && (hi_c <= r_c);
    status_o.leaf        = (cur_lo_q == cur_hi_q);
    status_o.sp_empty    = (sp_q == '0);
    status_o.top_phase   = stk_ph[top_idx];
    status_o.clr_done    = (clr_q == NW'(NS - 1));
    status_o.out_free    = !m_valid_q || m_axis_tready;
  end

  `LRAST_ASSERT_IMP(a_sp_bound, 1'b1, sp_q <= SPW'(SD), "walk stack beyond its depth")
  `LRAST_ASSERT_IMP(a_push_room, cmd_i.stk_push, sp_q < SPW'(SD), "push onto full stack")
  `LRAST_ASSERT_IMP(a_pop_nonempty, cmd_i.stk_pop, sp_q != '0, "pop from empty stack")
  `LRAST_ASSERT_NXT(a_out_load, cmd_i.out_load, m_valid_q && (out_q == $past(acc_q)),
                    "result not presented after load")

endmodule

// File: sv/lazy_range_add_sum_tree.sv
// Top level of the lazy range-add / range-sum segment tree.
//  channel   direction  transfer / write         payload
//  s_axis    in         tvalid & tready          tdata: opcode, low, high, operand
//  m_axis    out        tvalid & tready          tdata: range_total
//  cfg       in         cfg_we_i                 cfg_wdata_i: element_count
// One item at a time; a new item is taken only when the last is done. Add and
// sum walk the tree (4 log2 n nodes visited), bounded by the one read port of
// each node memory and the split tag multiply. A build visits every node.
// After reset, a pass clears all 4*MAX_ELEMENTS node slots before tready rises.
// A waiting result holds only a range-sum item at its end; others proceed.
module lazy_range_add_sum_tree
  import lrast_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] opcode, [11:2] range_low, [21:12] range_high, [53:22] operand_value
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [63:0] range_total
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  lrast_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lrast_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: dv/lazy_range_add_sum_tree_tb.sv
// Self-checking testbench for the lazy range-add / range-sum segment tree.
`timescale 1ns / 1ps

module lazy_range_add_sum_tree_tb
  import lrast_pkg::*;
();

  localparam int MaxElems  = 1024;
  localparam int NodeSlots = 4 * MaxElems;
  localparam int SettleCycles = 12000;

  typedef struct {
    opcode_e     op;
    logic [9:0]  lo;
    logic [9:0]  hi;
    logic [31:0] val;
  } tree_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;

  lazy_range_add_sum_tree #(.MAX_ELEMENTS(MaxElems)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_wdata_i
  );

  // Predicted tree state
  logic [63:0] tree_sum_mem [NodeSlots];
  logic [63:0] tree_tag_mem [NodeSlots];
  logic [31:0] elem_mem [MaxElems];
  logic [10:0] count_reg = 11'd1024;

  tree_item_t  pending_items[$];
  logic [63:0] expected_totals[$];
  tree_item_t  cur_item;
  bit          elem_loaded [MaxElems];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          items_sent = 0;
  int          fail_count = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  function automatic int unsigned live_count();
    int unsigned n;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > MaxElems) n = MaxElems;
    return n;
  endfunction

  function automatic void tree_tag(int unsigned nd, int unsigned lo, int unsigned hi,
                                   logic [63:0] amt);
    if (nd >= NodeSlots) return;
    tree_sum_mem[nd] += amt * 64'(hi - lo + 1);
    tree_tag_mem[nd] += amt;
  endfunction

  function automatic void tree_push(int unsigned nd, int unsigned lo, int unsigned hi);
    int unsigned mid;
    mid = lo + (hi - lo) / 2;
    tree_tag(2 * nd, lo, mid, tree_tag_mem[nd]);
    tree_tag(2 * nd + 1, mid + 1, hi, tree_tag_mem[nd]);
    tree_tag_mem[nd] = '0;
  endfunction

  function automatic void tree_build(int unsigned nd, int unsigned lo, int unsigned hi);
    int unsigned mid;
    if (nd >= NodeSlots) return;
    tree_tag_mem[nd] = '0;
    if (lo == hi) begin
      tree_sum_mem[nd] = {{32{elem_mem[lo][31]}}, elem_mem[lo]};
      return;
    end
    mid = lo + (hi - lo) / 2;
    tree_build(2 * nd, lo, mid);
    tree_build(2 * nd + 1, mid + 1, hi);
    tree_sum_mem[nd] = tree_sum_mem[2 * nd] + tree_sum_mem[2 * nd + 1];
  endfunction

  function automatic void tree_add(int unsigned nd, int unsigned lo, int unsigned hi,
                                   int unsigned l, int unsigned r, logic [63:0] amt);
    int unsigned mid;
    if (nd >= NodeSlots || lo > r || hi < l) return;
    if (l <= lo && hi <= r) begin
      tree_tag(nd, lo, hi, amt);
      return;
    end
    tree_push(nd, lo, hi);
    mid = lo + (hi - lo) / 2;
    tree_add(2 * nd, lo, mid, l, r, amt);
    tree_add(2 * nd + 1, mid + 1, hi, l, r, amt);
    tree_sum_mem[nd] = tree_sum_mem[2 * nd] + tree_sum_mem[2 * nd + 1];
  endfunction

  function automatic logic [63:0] tree_total(int unsigned nd, int unsigned lo,
                                             int unsigned hi, int unsigned l,
                                             int unsigned r);
    int unsigned mid;
    if (nd >= NodeSlots || lo > r || hi < l) return '0;
    if (l <= lo && hi <= r) return tree_sum_mem[nd];
    tree_push(nd, lo, hi);
    mid = lo + (hi - lo) / 2;
    return tree_total(2 * nd, lo, mid, l, r) + tree_total(2 * nd + 1, mid + 1, hi, l, r);
  endfunction

  // Apply one accepted item to the predicted tree
  function automatic void tree_apply(tree_item_t it);
    int unsigned n;
    n = live_count();
    case (it.op)
      OP_LOAD:  elem_mem[it.lo] = it.val;
      OP_BUILD: tree_build(1, 0, n - 1);
      OP_ADD:   if (it.lo <= it.hi)
                  tree_add(1, 0, n - 1, it.lo, it.hi, {{32{it.val[31]}}, it.val});
      default:  expected_totals.push_back((it.lo <= it.hi) ?
                                          tree_total(1, 0, n - 1, it.lo, it.hi) : 64'd0);
    endcase
  endfunction

  function automatic void queue_item(opcode_e op, int lo, int hi, logic [31:0] val);
    tree_item_t it;
    it.op = op;
    it.lo = lo[9:0];
    it.hi = hi[9:0];
    it.val = val;
    if (op == OP_LOAD) elem_loaded[lo] = 1'b1;
    pending_items.push_back(it);
  endfunction

  // A build must only read loaded positions: fill the gaps first
  function automatic void queue_build(int unsigned n);
    for (int i = 0; i < n; i++)
      if (!elem_loaded[i]) queue_item(OP_LOAD, i, 0, $urandom);
    queue_item(OP_BUILD, $urandom_range(1023), $urandom_range(1023), $urandom);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(7) - 3;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_random(int unsigned n);
    int lo;
    int hi;
    int unsigned r;
    r = $urandom_range(99);
    case ($urandom_range(9))
      0: begin lo = 0; hi = n - 1; end
      1: begin lo = $urandom_range(1023, 1); hi = $urandom_range(lo - 1); end
      2: begin
        lo = (n < MaxElems) ? $urandom_range(1023, n) : $urandom_range(1023);
        hi = $urandom_range(1023, lo);
      end
      3: begin lo = $urandom_range(n - 1); hi = 1023; end
      4: begin lo = $urandom_range(n - 1); hi = lo; end
      default: begin
        lo = $urandom_range(n - 1);
        hi = $urandom_range(n - 1, lo);
      end
    endcase
    if (r < 6) queue_item(OP_LOAD, $urandom_range(1023), $urandom_range(1023), pick_value());
    else if (r < 9 && n <= 128) queue_build(n);
    else if (r < 50) queue_item(OP_ADD, lo, hi, pick_value());
    else queue_item(OP_SUM, lo, hi, $urandom);
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_totals.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_count(logic [10:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    count_reg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sender: one transfer per accepted item, fed from the pending queue
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      tree_apply(cur_item);
      items_sent++;
    end
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_item = pending_items.pop_front();
        s_axis_tdata <= {2'b00, cur_item.val, cur_item.hi, cur_item.lo, cur_item.op};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready, with one long hold-off partway through the run
  always @(posedge clk_i) begin
    if (!hold_done && items_sent >= 400) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result check against the oldest predicted total
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_totals.size() == 0) begin
        $error("range_total: no result expected, got %h", m_axis_tdata);
        fail_count++;
      end else if (m_axis_tdata !== expected_totals[0]) begin
        $error("range_total: expected %h, got %h", expected_totals[0], m_axis_tdata);
        fail_count++;
        void'(expected_totals.pop_front());
      end else begin
        void'(expected_totals.pop_front());
      end
    end
  end

  // Stimulus phases
  initial begin
    int counts[9];
    counts = '{8, 16, 1, 0, 1024, 2047, 5, 100, 3};
    for (int i = 0; i < NodeSlots; i++) begin
      tree_sum_mem[i] = '0;
      tree_tag_mem[i] = '0;
    end
    foreach (elem_loaded[i]) elem_loaded[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (counts[p]) begin
      int unsigned n;
      wait_idle();
      write_count(counts[p][10:0]);
      n = live_count();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (p == 0) begin
        // Directed: extreme values, empty, outside and clipped ranges
        queue_item(OP_LOAD, 0, 1023, 32'h7fff_ffff);
        queue_item(OP_LOAD, 1, 0, 32'h8000_0000);
        queue_item(OP_LOAD, 2, 0, 32'hffff_ffff);
        queue_item(OP_LOAD, 3, 0, 32'h0);
        queue_item(OP_LOAD, 1023, 0, 32'h1234_5678);
        queue_build(n);
        queue_item(OP_SUM, 0, n - 1, 0);
        queue_item(OP_SUM, 0, 0, 0);
        queue_item(OP_SUM, n - 1, n - 1, 0);
        queue_item(OP_SUM, 3, 2, 0);
        queue_item(OP_SUM, 1023, 1023, 0);
        queue_item(OP_SUM, 5, 1023, 0);
        queue_item(OP_ADD, 0, n - 1, 32'h7fff_ffff);
        queue_item(OP_ADD, 2, 5, 32'h8000_0000);
        queue_item(OP_ADD, 9, 1000, 32'h5);
        queue_item(OP_ADD, 4, 3, 32'h7);
        queue_item(OP_SUM, 0, 1023, 0);
        queue_item(OP_SUM, 3, 4, 0);
        queue_item(OP_ADD, 1, 6, 32'hffff_fffe);
        queue_item(OP_SUM, 2, 2, 0);
        queue_item(OP_SUM, 0, 7, 0);
      end else if (counts[p] != 5) begin
        // The count-5 phase keeps the old tree under a new shape
        queue_build(n);
      end
      for (int k = 0; k < 110; k++) queue_random(n);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/lrast_pkg.sv
sv/lrast_ctrl.sv
sv/lrast_dp.sv
sv/lazy_range_add_sum_tree.sv
dv/lazy_range_add_sum_tree_tb.sv
